// ===== sv/rmsprop_optimizer_update_unit_macros.svh =====
// Assertion macros for the RMSProp update unit.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef RMSPROP_OPTIMIZER_UPDATE_UNIT_MACROS_SVH
`define RMSPROP_OPTIMIZER_UPDATE_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define RMSP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define RMSP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/rmsp_pkg.sv =====
// Shared constants and types for the RMSProp update unit.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package rmsp_pkg;

    localparam int VW     = 32;   // value width
    localparam int FB     = 24;   // fraction bits
    localparam int CW     = 25;   // config register width
    localparam int MSW    = 31;   // mean square width
    localparam int NUM_W  = 58;   // lr * g, signed
    localparam int MAG_W  = 57;   // |lr * g|
    localparam int PM_W   = 34;   // rescaled mom * momentum_factor
    localparam int DEN_W  = 33;   // denominator
    localparam int SQ_N   = 29;   // sqrt stages, one root bit each
    localparam int ROOT_W = 29;
    localparam int REM_W  = 30;
    localparam int QW     = 34;   // quotient bits kept below the cap
    localparam int IDX_W  = 3;

    localparam longint ONE_FX  = 64'sd1 <<< FB;
    localparam longint HALF_FX = 64'sd1 <<< (FB - 1);
    localparam longint V_MAX   = (64'sd1 <<< (VW - 1)) - 1;
    localparam longint V_MIN   = -(64'sd1 <<< (VW - 1));
    localparam longint MS_MAX  = (64'sd1 <<< MSW) - 1;

    // reset values of the config registers
    localparam logic [CW-1:0] LR_RST  = CW'(16777);
    localparam logic [CW-1:0] RHO_RST = CW'(15099494);
    localparam logic [CW-1:0] MF_RST  = CW'(0);
    localparam logic [CW-1:0] EPS_RST = CW'(1);

    typedef enum logic [IDX_W-1:0] {
        REG_LR  = 3'd0,
        REG_RHO = 3'd1,
        REG_MF  = 3'd2,
        REG_EPS = 3'd3,
        REG_CEN = 3'd4
    } cfg_index_t;

    // per-item payload carried alongside the sqrt / divide pipes
    typedef struct packed {
        logic signed [VW-1:0]   w;
        logic [MSW-1:0]         ms;
        logic signed [VW-1:0]   mg;
        logic signed [PM_W-1:0] pmom;
        logic                   neg;
        logic [MAG_W-1:0]       mag;
        logic                   flag;
    } side_t;

endpackage

`default_nettype wire

// ===== sv/rmsp_front.sv =====
// Front pipe: mean square, mean gradient and denominator, six stages.
// Depends on rmsp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rmsp_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic signed [rmsp_pkg::VW-1:0] weight_in,
    input  wire logic [rmsp_pkg::MSW-1:0]      mean_square_in,
    input  wire logic signed [rmsp_pkg::VW-1:0] mean_grad_in,
    input  wire logic signed [rmsp_pkg::VW-1:0] momentum_in,
    input  wire logic signed [rmsp_pkg::VW-1:0] gradient,
    input  wire logic [rmsp_pkg::CW-1:0]       learning_rate,
    input  wire logic [rmsp_pkg::CW-1:0]       decay_rate,
    input  wire logic [rmsp_pkg::CW-1:0]       momentum_factor,
    input  wire logic [rmsp_pkg::CW-1:0]       stability_eps,
    input  wire logic                          centered_mode,
    output logic                               out_valid,
    output logic [rmsp_pkg::DEN_W-1:0]         out_den,
    output rmsp_pkg::side_t                    out_side
);

    // stage valids
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;

    // stage 1: products of the raw inputs
    logic signed [63:0] gg1_reg, gg1_next;
    logic signed [32:0] dg1_reg, dg1_next;
    logic signed [rmsp_pkg::NUM_W-1:0] num1_reg, num1_next;
    logic signed [57:0] mm1_reg, mm1_next;
    logic signed [31:0] w1_reg, mg1_reg;
    logic [30:0] ms1_reg;

    assign gg1_next  = gradient * gradient;
    assign dg1_next  = $signed({gradient[31], gradient}) -
                       $signed({mean_grad_in[31], mean_grad_in});
    assign num1_next = $signed({1'b0, learning_rate}) * gradient;
    assign mm1_next  = momentum_in * $signed({1'b0, momentum_factor});

    // stage 2: rescale, g2 - ms, |lr*g|
    logic signed [63:0] gs2;
    logic signed [39:0] g2;
    logic signed [57:0] ms2s;
    logic [rmsp_pkg::NUM_W-1:0] absn;
    logic signed [40:0] diff2_reg, diff2_next;
    logic signed [32:0] dg2_reg;
    logic signed [rmsp_pkg::PM_W-1:0] pm2_reg;
    logic neg2_reg;
    logic [rmsp_pkg::MAG_W-1:0] mag2_reg;
    logic signed [31:0] w2_reg, mg2_reg;
    logic [30:0] ms2_reg;

    assign gs2        = gg1_reg + 64'(rmsp_pkg::HALF_FX);
    assign g2         = gs2[63:24];
    assign diff2_next = $signed({g2[39], g2}) - $signed({10'b0, ms1_reg});
    assign ms2s       = mm1_reg + 58'(rmsp_pkg::HALF_FX);
    assign absn       = num1_reg[rmsp_pkg::NUM_W-1] ? rmsp_pkg::NUM_W'(-num1_reg)
                                                   : rmsp_pkg::NUM_W'(num1_reg);

    // stage 3: (1 - rho) products
    logic signed [25:0] omr;
    logic signed [66:0] pmul3_reg, pmul3_next;
    logic signed [58:0] gmul3_reg, gmul3_next;
    logic signed [rmsp_pkg::PM_W-1:0] pm3_reg;
    logic neg3_reg;
    logic [rmsp_pkg::MAG_W-1:0] mag3_reg;
    logic signed [31:0] w3_reg, mg3_reg;
    logic [30:0] ms3_reg;

    assign omr        = $signed(26'(rmsp_pkg::ONE_FX)) - $signed({1'b0, decay_rate});
    assign pmul3_next = omr * diff2_reg;
    assign gmul3_next = omr * dg2_reg;

    // stage 4: new mean square and mean gradient, clipped
    logic signed [66:0] ps4;
    logic signed [58:0] gs4;
    logic signed [43:0] msum4;
    logic signed [35:0] mgsum4;
    logic [30:0] ms4_next, ms4_reg;
    logic signed [31:0] mg4_next, mg4_reg;
    logic flag4_next, flag4_reg;
    logic ms_clip, mg_clip;
    logic signed [rmsp_pkg::PM_W-1:0] pm4_reg;
    logic neg4_reg;
    logic [rmsp_pkg::MAG_W-1:0] mag4_reg;
    logic signed [31:0] w4_reg;

    assign ps4    = pmul3_reg + 67'(rmsp_pkg::HALF_FX);
    assign gs4    = gmul3_reg + 59'(rmsp_pkg::HALF_FX);
    assign msum4  = $signed({13'b0, ms3_reg}) + $signed({ps4[66], ps4[66:24]});
    assign mgsum4 = $signed({{4{mg3_reg[31]}}, mg3_reg}) + $signed({gs4[58], gs4[58:24]});

    always_comb
    begin
        ms_clip = 1'b1;
        if (msum4 < 44'sd0)
            ms4_next = '0;
        else if (msum4 > 44'(rmsp_pkg::MS_MAX))
            ms4_next = 31'(rmsp_pkg::MS_MAX);
        else
        begin
            ms4_next = msum4[30:0];
            ms_clip  = 1'b0;
        end
        mg_clip = 1'b0;
        if (!centered_mode)
            mg4_next = mg3_reg;
        else if (mgsum4 < 36'(rmsp_pkg::V_MIN))
        begin
            mg4_next = 32'(rmsp_pkg::V_MIN);
            mg_clip  = 1'b1;
        end
        else if (mgsum4 > 36'(rmsp_pkg::V_MAX))
        begin
            mg4_next = 32'(rmsp_pkg::V_MAX);
            mg_clip  = 1'b1;
        end
        else
            mg4_next = mgsum4[31:0];
        flag4_next = ms_clip | mg_clip;
    end

    // stage 5: mg'^2
    logic signed [63:0] mgsq5_reg, mgsq5_next;
    rmsp_pkg::side_t side5_reg, side5_next;

    assign mgsq5_next = mg4_reg * mg4_reg;
    always_comb
    begin
        side5_next      = '0;
        side5_next.w    = w4_reg;
        side5_next.ms   = ms4_reg;
        side5_next.mg   = mg4_reg;
        side5_next.pmom = pm4_reg;
        side5_next.neg  = neg4_reg;
        side5_next.mag  = mag4_reg;
        side5_next.flag = flag4_reg;
    end

    // stage 6: denominator, clamped at zero
    logic signed [63:0] qs6;
    logic signed [41:0] dc6;
    logic [rmsp_pkg::DEN_W-1:0] den6_next, den6_reg;
    rmsp_pkg::side_t side6_reg;

    assign qs6 = mgsq5_reg + 64'(rmsp_pkg::HALF_FX);
    assign dc6 = $signed({11'b0, side5_reg.ms}) - $signed({{2{qs6[63]}}, qs6[63:24]})
               + $signed({17'b0, stability_eps});

    always_comb
    begin
        if (centered_mode)
            den6_next = (dc6 < 42'sd0) ? '0 : dc6[rmsp_pkg::DEN_W-1:0];
        else
            den6_next = {2'b0, side5_reg.ms} + {8'b0, stability_eps};
    end

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            gg1_reg   <= gg1_next;
            dg1_reg   <= dg1_next;
            num1_reg  <= num1_next;
            mm1_reg   <= mm1_next;
            w1_reg    <= weight_in;
            ms1_reg   <= mean_square_in;
            mg1_reg   <= mean_grad_in;

            diff2_reg <= diff2_next;
            dg2_reg   <= dg1_reg;
            pm2_reg   <= ms2s[57:24];
            neg2_reg  <= num1_reg[rmsp_pkg::NUM_W-1];
            mag2_reg  <= absn[rmsp_pkg::MAG_W-1:0];
            w2_reg    <= w1_reg;
            ms2_reg   <= ms1_reg;
            mg2_reg   <= mg1_reg;

            pmul3_reg <= pmul3_next;
            gmul3_reg <= gmul3_next;
            pm3_reg   <= pm2_reg;
            neg3_reg  <= neg2_reg;
            mag3_reg  <= mag2_reg;
            w3_reg    <= w2_reg;
            ms3_reg   <= ms2_reg;
            mg3_reg   <= mg2_reg;

            ms4_reg   <= ms4_next;
            mg4_reg   <= mg4_next;
            flag4_reg <= flag4_next;
            pm4_reg   <= pm3_reg;
            neg4_reg  <= neg3_reg;
            mag4_reg  <= mag3_reg;
            w4_reg    <= w3_reg;

            mgsq5_reg <= mgsq5_next;
            side5_reg <= side5_next;

            den6_reg  <= den6_next;
            side6_reg <= side5_reg;
        end
    end

    assign out_valid = v6_reg;
    assign out_den   = den6_reg;
    assign out_side  = side6_reg;

endmodule

`default_nettype wire

// ===== sv/rmsp_sqrt.sv =====
// Pipelined integer square root of den * 2^24, one root bit per stage.
// Depends on rmsp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rmsp_sqrt (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic [rmsp_pkg::DEN_W-1:0]    in_den,
    input  wire rmsp_pkg::side_t               in_side,
    output logic                               out_valid,
    output logic [rmsp_pkg::ROOT_W-1:0]        out_root,
    output logic                               out_dz,
    output rmsp_pkg::side_t                    out_side
);

    localparam int N  = rmsp_pkg::SQ_N;
    localparam int XW = 2 * N;

    logic                         v_reg    [N];
    logic [rmsp_pkg::REM_W-1:0]   rem_reg  [N];
    logic [rmsp_pkg::ROOT_W-1:0]  root_reg [N];
    logic [rmsp_pkg::DEN_W-1:0]   den_reg  [N];
    logic                         dz_reg   [N];
    rmsp_pkg::side_t              side_reg [N];

    for (genvar i = 0; i < N; i++)
    begin : g_stage
        logic                         v_i;
        logic [rmsp_pkg::REM_W-1:0]   rem_i;
        logic [rmsp_pkg::ROOT_W-1:0]  root_i;
        logic [rmsp_pkg::DEN_W-1:0]   den_i;
        logic                         dz_i;
        rmsp_pkg::side_t              side_i;
        logic [XW-1:0]                xw;
        logic [rmsp_pkg::REM_W+1:0]   t, trial;
        logic                         ge;

        if (i == 0)
        begin : g_first
            assign v_i    = in_valid;
            assign rem_i  = '0;
            assign root_i = '0;
            assign den_i  = in_den;
            assign dz_i   = (in_den == '0);
            assign side_i = in_side;
        end
        else
        begin : g_next
            assign v_i    = v_reg[i-1];
            assign rem_i  = rem_reg[i-1];
            assign root_i = root_reg[i-1];
            assign den_i  = den_reg[i-1];
            assign dz_i   = dz_reg[i-1];
            assign side_i = side_reg[i-1];
        end

        // radicand bit pair for this stage
        assign xw    = {1'b0, den_i, {rmsp_pkg::FB{1'b0}}};
        assign t     = {rem_i, xw[XW-1-2*i -: 2]};
        assign trial = {1'b0, root_i, 2'b01};
        assign ge    = (t >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i] <= 1'b0;
            else if (en)
                v_reg[i] <= v_i;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= ge ? rmsp_pkg::REM_W'(t - trial) : t[rmsp_pkg::REM_W-1:0];
                root_reg[i] <= {root_i[rmsp_pkg::ROOT_W-2:0], ge};
                den_reg[i]  <= den_i;
                dz_reg[i]   <= dz_i;
                side_reg[i] <= side_i;
            end
        end
    end

    assign out_valid = v_reg[N-1];
    assign out_root  = root_reg[N-1];
    assign out_dz    = dz_reg[N-1];
    assign out_side  = side_reg[N-1];

endmodule

`default_nettype wire

// ===== sv/rmsp_div.sv =====
// Pipelined rounded divide |lr*g| / sqrt(den), one quotient bit per stage.
// Quotients at or above 2^34 saturate; a zero denominator forces saturation
// when |lr*g| is nonzero. Depends on rmsp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rmsp_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic [rmsp_pkg::ROOT_W-1:0]   in_root,
    input  wire logic                          in_dz,
    input  wire rmsp_pkg::side_t               in_side,
    output logic                               out_valid,
    output logic [rmsp_pkg::QW-1:0]            out_q,
    output logic                               out_ovf,
    output rmsp_pkg::side_t                    out_side
);

    localparam int N  = rmsp_pkg::QW;
    localparam int RW = rmsp_pkg::ROOT_W;
    localparam int DW = rmsp_pkg::MAG_W + 1;

    // prep stage: rounding offset, divisor, overflow check
    logic [RW-1:0] sdiv;
    logic [DW-1:0] dividend;
    logic [DW-N-1:0] hi;
    logic ovf_next;
    rmsp_pkg::side_t side_p;

    assign sdiv     = (in_root == '0) ? RW'(1) : in_root;
    assign dividend = {1'b0, in_side.mag} + DW'(sdiv[RW-1:1]);
    assign hi       = dividend[DW-1:N];
    assign ovf_next = in_dz ? (in_side.mag != '0) : (RW'(hi) >= sdiv);

    always_comb
    begin
        side_p      = in_side;
        side_p.flag = in_side.flag | in_dz;
    end

    logic            vp_reg;
    logic [RW-1:0]   sp_reg, remp_reg;
    logic [N-1:0]    lowp_reg;
    logic            ovfp_reg;
    rmsp_pkg::side_t sidep_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vp_reg <= 1'b0;
        else if (en)
            vp_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sp_reg    <= sdiv;
            remp_reg  <= RW'(hi);
            lowp_reg  <= dividend[N-1:0];
            ovfp_reg  <= ovf_next;
            sidep_reg <= side_p;
        end
    end

    // restoring divide stages
    logic            v_reg    [N];
    logic [RW-1:0]   s_reg    [N];
    logic [RW-1:0]   rem_reg  [N];
    logic [N-1:0]    low_reg  [N];
    logic [N-1:0]    q_reg    [N];
    logic            ovf_reg  [N];
    rmsp_pkg::side_t side_reg [N];

    for (genvar j = 0; j < N; j++)
    begin : g_stage
        logic            v_i, ovf_i, ge;
        logic [RW-1:0]   s_i, rem_i;
        logic [N-1:0]    low_i, q_i;
        rmsp_pkg::side_t side_i;
        logic [RW:0]     t;

        if (j == 0)
        begin : g_first
            assign v_i    = vp_reg;
            assign s_i    = sp_reg;
            assign rem_i  = remp_reg;
            assign low_i  = lowp_reg;
            assign q_i    = '0;
            assign ovf_i  = ovfp_reg;
            assign side_i = sidep_reg;
        end
        else
        begin : g_next
            assign v_i    = v_reg[j-1];
            assign s_i    = s_reg[j-1];
            assign rem_i  = rem_reg[j-1];
            assign low_i  = low_reg[j-1];
            assign q_i    = q_reg[j-1];
            assign ovf_i  = ovf_reg[j-1];
            assign side_i = side_reg[j-1];
        end

        assign t  = {rem_i, low_i[N-1]};
        assign ge = (t >= {1'b0, s_i});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[j] <= 1'b0;
            else if (en)
                v_reg[j] <= v_i;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j]  <= ge ? RW'(t - {1'b0, s_i}) : t[RW-1:0];
                q_reg[j]    <= {q_i[N-2:0], ge};
                low_reg[j]  <= {low_i[N-2:0], 1'b0};
                s_reg[j]    <= s_i;
                ovf_reg[j]  <= ovf_i;
                side_reg[j] <= side_i;
            end
        end
    end

    assign out_valid = v_reg[N-1];
    assign out_q     = q_reg[N-1];
    assign out_ovf   = ovf_reg[N-1];
    assign out_side  = side_reg[N-1];

endmodule

`default_nettype wire

// ===== sv/rmsp_back.sv =====
// Back end: momentum and weight update with saturation, output skid buffer.
// Produces the pipeline advance enable. Depends on rmsp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rmsp_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic [rmsp_pkg::QW-1:0]       in_q,
    input  wire logic                          in_ovf,
    input  wire rmsp_pkg::side_t               in_side,
    output logic                               en,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [127:0]                       m_tdata,
    output logic                               m_tuser
);

    localparam int TW = rmsp_pkg::QW + 2;   // signed step term

    // stage A: mom' = rescale(mom*mf) + term, clipped
    logic [rmsp_pkg::QW:0] qmag;
    logic signed [TW-1:0]  term;
    logic signed [TW:0]    msum;
    logic signed [31:0]    mom_next;
    logic                  mom_clip;

    assign qmag = in_ovf ? ((rmsp_pkg::QW+1)'(1) << rmsp_pkg::QW) : {1'b0, in_q};
    assign term = in_side.neg ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
    assign msum = (TW+1)'(in_side.pmom) + (TW+1)'(term);

    always_comb
    begin
        mom_clip = 1'b1;
        if (msum < (TW+1)'(rmsp_pkg::V_MIN))
            mom_next = 32'(rmsp_pkg::V_MIN);
        else if (msum > (TW+1)'(rmsp_pkg::V_MAX))
            mom_next = 32'(rmsp_pkg::V_MAX);
        else
        begin
            mom_next = msum[31:0];
            mom_clip = 1'b0;
        end
    end

    logic               va_reg;
    logic signed [31:0] moma_reg, wa_reg, mga_reg;
    logic [30:0]        msa_reg;
    logic               flaga_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            va_reg <= 1'b0;
        else if (en)
            va_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            moma_reg  <= mom_next;
            wa_reg    <= in_side.w;
            mga_reg   <= in_side.mg;
            msa_reg   <= in_side.ms;
            flaga_reg <= in_side.flag | mom_clip;
        end
    end

    // stage B: w' = w - mom', clipped
    logic signed [32:0] wd;
    logic signed [31:0] w_new;
    logic               w_clip;
    logic [127:0]       res_data;
    logic               res_flag;

    assign wd = $signed({wa_reg[31], wa_reg}) - $signed({moma_reg[31], moma_reg});

    always_comb
    begin
        w_clip = 1'b1;
        if (wd < 33'(rmsp_pkg::V_MIN))
            w_new = 32'(rmsp_pkg::V_MIN);
        else if (wd > 33'(rmsp_pkg::V_MAX))
            w_new = 32'(rmsp_pkg::V_MAX);
        else
        begin
            w_new  = wd[31:0];
            w_clip = 1'b0;
        end
    end

    assign res_data = {1'b0, moma_reg, mga_reg, msa_reg, w_new};
    assign res_flag = flaga_reg | w_clip;

    // output register plus skid entry; pipe advances while skid is empty
    logic         out_valid_reg, skid_valid_reg;
    logic [127:0] out_data_reg, skid_data_reg;
    logic         out_flag_reg, skid_flag_reg;
    logic         take, load_out, load_skid;

    assign en        = !skid_valid_reg;
    assign take      = out_valid_reg && m_tready;
    assign load_out  = !skid_valid_reg && (!out_valid_reg || take);
    assign load_skid = !skid_valid_reg && va_reg && out_valid_reg && !take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (take)
                skid_valid_reg <= 1'b0;
        end
        else if (load_out)
            out_valid_reg <= va_reg;
        else if (load_skid)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg && take)
        begin
            out_data_reg <= skid_data_reg;
            out_flag_reg <= skid_flag_reg;
        end
        else if (load_out)
        begin
            out_data_reg <= res_data;
            out_flag_reg <= res_flag;
        end
        if (load_skid)
        begin
            skid_data_reg <= res_data;
            skid_flag_reg <= res_flag;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_flag_reg;

endmodule

`default_nettype wire

// ===== sv/rmsprop_optimizer_update_unit.sv =====
// Top level of the RMSProp update unit: config registers, pipe instances.
// Depends on rmsp_pkg, rmsp_front, rmsp_sqrt, rmsp_div, rmsp_back and the macro header.
//
//   channel   direction  handshake            payload
//   s_*       in         s_tvalid / s_tready  s_tdata: weight, mean square, mean grad,
//                                             momentum, gradient
//   m_*       out        m_tvalid / m_tready  m_tdata: weight, mean square, mean grad,
//                                             momentum; m_tuser: saturated
//   cfg_*     in         cfg_wr_en            cfg_index, cfg_data
//
// One transaction per cycle sustained while m_tready stays high; the 29 root
// stages and the 35 divide stages lie between the front and back pipes.
// Reset clears all valid bits and loads the config defaults.
// A stall on m_tready fills the skid entry; the whole pipe then holds and
// s_tready drops, so nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none
`include "rmsprop_optimizer_update_unit_macros.svh"

module rmsprop_optimizer_update_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // weight[31:0], mean_square[62:32], mean_grad[94:63], momentum[126:95],
    // gradient[158:127], zero pad
    input  wire logic [159:0]                   s_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // weight[31:0], mean_square[62:32], mean_grad[94:63], momentum[126:95], zero pad
    output logic [127:0]                        m_tdata,
    // saturated[0]
    output logic                                m_tuser,
    input  wire logic                           cfg_wr_en,
    input  wire logic [rmsp_pkg::IDX_W-1:0]     cfg_index,
    input  wire logic [rmsp_pkg::CW-1:0]        cfg_data
);

    // configuration registers
    logic [rmsp_pkg::CW-1:0] lr_reg, rho_reg, mf_reg, eps_reg;
    logic                    cen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lr_reg  <= rmsp_pkg::LR_RST;
            rho_reg <= rmsp_pkg::RHO_RST;
            mf_reg  <= rmsp_pkg::MF_RST;
            eps_reg <= rmsp_pkg::EPS_RST;
            cen_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (rmsp_pkg::cfg_index_t'(cfg_index))
                rmsp_pkg::REG_LR:  lr_reg  <= cfg_data;
                rmsp_pkg::REG_RHO: rho_reg <= cfg_data;
                rmsp_pkg::REG_MF:  mf_reg  <= cfg_data;
                rmsp_pkg::REG_EPS: eps_reg <= cfg_data;
                rmsp_pkg::REG_CEN: cen_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    logic en;
    assign s_tready = en;

    // front pipe
    logic                         f_valid;
    logic [rmsp_pkg::DEN_W-1:0]   f_den;
    rmsp_pkg::side_t              f_side;

    rmsp_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .en              (en),
        .in_valid        (s_tvalid),
        .weight_in       ($signed(s_tdata[31:0])),
        .mean_square_in  (s_tdata[62:32]),
        .mean_grad_in    ($signed(s_tdata[94:63])),
        .momentum_in     ($signed(s_tdata[126:95])),
        .gradient        ($signed(s_tdata[158:127])),
        .learning_rate   (lr_reg),
        .decay_rate      (rho_reg),
        .momentum_factor (mf_reg),
        .stability_eps   (eps_reg),
        .centered_mode   (cen_reg),
        .out_valid       (f_valid),
        .out_den         (f_den),
        .out_side        (f_side)
    );

    // square root pipe
    logic                         r_valid, r_dz;
    logic [rmsp_pkg::ROOT_W-1:0]  r_root;
    rmsp_pkg::side_t              r_side;

    rmsp_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_valid),
        .in_den    (f_den),
        .in_side   (f_side),
        .out_valid (r_valid),
        .out_root  (r_root),
        .out_dz    (r_dz),
        .out_side  (r_side)
    );

    // divide pipe
    logic                         d_valid, d_ovf;
    logic [rmsp_pkg::QW-1:0]      d_q;
    rmsp_pkg::side_t              d_side;

    rmsp_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (r_valid),
        .in_root   (r_root),
        .in_dz     (r_dz),
        .in_side   (r_side),
        .out_valid (d_valid),
        .out_q     (d_q),
        .out_ovf   (d_ovf),
        .out_side  (d_side)
    );

    // update, saturation and output buffering
    rmsp_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (d_valid),
        .in_q     (d_q),
        .in_ovf   (d_ovf),
        .in_side  (d_side),
        .en       (en),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // checks
    `RMSP_ASSERT_IMP(a_hold_has_output, !s_tready, m_tvalid, "pipe held with no output pending")
    `RMSP_ASSERT_NEXT(a_hold_while_stalled, !s_tready && !m_tready, !s_tready, "pipe released while stalled")
    `RMSP_ASSERT_NEXT(a_skid_drains, !s_tready && m_tvalid && m_tready, s_tready, "skid entry not drained")

endmodule

`default_nettype wire

// ===== tb/tb_rmsprop_optimizer_update_unit.sv =====
// Testbench for the RMSProp update unit: random and corner-case elements under
// several register settings and flow-control phases. Depends on rmsp_pkg and the RTL.
`timescale 1ns / 1ps
`default_nettype none

class rmsp_scoreboard;
    logic [127:0] exp_data[$];
    logic         exp_sat[$];
    int           mismatches;

    logic [24:0]  lr, rho, mf, eps;
    logic         cen;

    function new();
        mismatches = 0;
        lr = 25'd16777;
        rho = 25'd15099494;
        mf = 25'd0;
        eps = 25'd1;
        cen = 1'b0;
    endfunction

    function void set_reg(int idx, logic [24:0] val);
        case (idx)
            rmsp_pkg::REG_LR:  lr = val;
            rmsp_pkg::REG_RHO: rho = val;
            rmsp_pkg::REG_MF:  mf = val;
            rmsp_pkg::REG_EPS: eps = val;
            rmsp_pkg::REG_CEN: cen = val[0];
            default: ;
        endcase
    endfunction

    // Q8.24 product rescale, round half up (arithmetic shift is floor)
    function longint rescale(longint p);
        return (p + (64'sd1 <<< 23)) >>> 24;
    endfunction

    function longint clip(longint x, longint lo, longint hi, ref bit flag);
        if (x < lo) begin flag = 1; return lo; end
        if (x > hi) begin flag = 1; return hi; end
        return x;
    endfunction

    function longint unsigned root_floor(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    // Predict one update from an accepted input transaction
    function void note_element(logic [159:0] d);
        longint w, ms, mg, mom, g, omr, g2, msn, mgn, den, num, term, momn, wn;
        longint unsigned s, mag, q;
        bit flag;
        flag = 0;
        w = longint'($signed(d[31:0]));
        ms = longint'(d[62:32]);
        mg = longint'($signed(d[94:63]));
        mom = longint'($signed(d[126:95]));
        g = longint'($signed(d[158:127]));
        omr = (64'sd1 <<< 24) - longint'(rho);
        g2 = rescale(g * g);
        msn = clip(ms + rescale(omr * (g2 - ms)), 0, rmsp_pkg::V_MAX, flag);
        mgn = mg;
        if (cen)
        begin
            mgn = clip(mg + rescale(omr * (g - mg)), rmsp_pkg::V_MIN, rmsp_pkg::V_MAX, flag);
            den = msn - rescale(mgn * mgn) + longint'(eps);
            if (den < 0) den = 0;
        end
        else
            den = msn + longint'(eps);
        num = longint'(lr) * g;
        if (den == 0)
        begin
            flag = 1;
            term = num > 0 ? (64'sd1 <<< 34) : (num < 0 ? -(64'sd1 <<< 34) : 0);
        end
        else
        begin
            s = root_floor(longint'(den) << 24);
            if (s == 0) s = 1;
            mag = num < 0 ? longint'(-num) : longint'(num);
            q = (mag + s / 2) / s;
            term = num < 0 ? -longint'(q) : longint'(q);
        end
        momn = clip(rescale(mom * longint'(mf)) + term, rmsp_pkg::V_MIN,
                    rmsp_pkg::V_MAX, flag);
        wn = clip(w - momn, rmsp_pkg::V_MIN, rmsp_pkg::V_MAX, flag);
        exp_data.push_back({1'b0, momn[31:0], mgn[31:0], msn[30:0], wn[31:0]});
        exp_sat.push_back(flag);
    endfunction

    function void check_update(logic [127:0] d, logic sat);
        logic [127:0] e;
        logic es;
        if (exp_data.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected output transaction data=%h sat=%b", d, sat);
            return;
        end
        e = exp_data.pop_front();
        es = exp_sat.pop_front();
        if (d[31:0] !== e[31:0] || d[62:32] !== e[62:32] || d[94:63] !== e[94:63]
            || d[126:95] !== e[126:95] || d[127] !== 1'b0 || sat !== es)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: w %h/%h ms %h/%h mg %h/%h mom %h/%h sat %b/%b",
                         e[31:0], d[31:0], e[62:32], d[62:32], e[94:63], d[94:63],
                         e[126:95], d[126:95], es, sat);
        end
    endfunction
endclass

module tb_rmsprop_optimizer_update_unit;

    logic clk, rst_n;
    logic s_tvalid, s_tready, m_tvalid, m_tready, m_tuser;
    logic [159:0] s_tdata;
    logic [127:0] m_tdata;
    logic cfg_wr_en;
    logic [rmsp_pkg::IDX_W-1:0] cfg_index;
    logic [rmsp_pkg::CW-1:0] cfg_data;

    rmsp_scoreboard board;
    int send_idle_pct, recv_stall_pct;
    longint cycles;

    rmsprop_optimizer_update_unit dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Cycle limit
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 400000)
            begin
                $display("FAIL rmsprop_optimizer_update_unit");
                $finish;
            end
        end
    end

    // Output side: sample at rising edge, randomize ready at falling edge
    initial
    begin
        m_tready = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                board.check_update(m_tdata, m_tuser);
            @(negedge clk);
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic write_reg(rmsp_pkg::cfg_index_t idx, logic [rmsp_pkg::CW-1:0] val);
        @(negedge clk);
        cfg_wr_en <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        board.set_reg(idx, val);
        @(negedge clk);
        cfg_wr_en <= 0;
    endtask

    // valid stays high after acceptance; drain() or next-call idling drops it
    task automatic send_element(logic [159:0] d);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 0;
            @(negedge clk);
        end
        s_tvalid <= 1;
        s_tdata <= d;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        board.note_element(d);
        @(negedge clk);
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(5))
            0: return $urandom;
            1: return 32'($signed($urandom_range(16777216 * 4)) - 33554432);
            2: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
            default: return 32'($signed($urandom_range(2097152)) - 1048576);
        endcase
    endfunction

    function automatic logic [159:0] rand_element();
        logic [30:0] ms;
        ms = $urandom_range(2) == 0 ? 31'($urandom) : 31'($urandom_range(4194304));
        return {1'b0, rand_value(), rand_value(), rand_value(), ms, rand_value()};
    endfunction

    task automatic drain();
        s_tvalid <= 0;
        while (board.exp_data.size() != 0) @(negedge clk);
        repeat (80) @(negedge clk);
    endtask

    initial
    begin
        board = new();
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = '0;
        cfg_wr_en = 0;
        cfg_index = '0;
        cfg_data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // Directed: field extremes at reset settings, then centered corners
        send_element('0);
        send_element({1'b0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 31'h7fffffff,
                      32'h7fffffff});
        send_element({1'b0, 32'h80000000, 32'h80000000, 32'h80000000, 31'd0, 32'h80000000});
        send_element({1'b0, 32'h01000000, 32'd0, 32'd0, 31'd0, 32'h80000000});
        drain();
        // Eps zero: zero denominator with zero mean square and gradient, then zero decay
        write_reg(rmsp_pkg::REG_EPS, 25'd0);
        write_reg(rmsp_pkg::REG_RHO, 25'h1000000);
        send_element('0);
        send_element({1'b0, 32'h00000100, 32'd0, 32'd0, 31'd0, 32'd0});
        drain();
        write_reg(rmsp_pkg::REG_RHO, 25'd0);
        send_element({1'b0, 32'hff000000, 32'd0, 32'd0, 31'd0, 32'd0});
        send_element({1'b0, 32'h01000000, 32'd0, 32'd0, 31'd0, 32'd0});
        drain();
        // Centered, negative variance clamped, decay above one, max momentum
        write_reg(rmsp_pkg::REG_CEN, 25'd1);
        write_reg(rmsp_pkg::REG_RHO, 25'h1ffffff);
        write_reg(rmsp_pkg::REG_MF, 25'h1ffffff);
        write_reg(rmsp_pkg::REG_LR, 25'h1ffffff);
        send_element({1'b0, 32'h01000000, 32'h7fffffff, 32'h10000000, 31'd0, 32'h02000000});
        send_element({1'b0, 32'h80000000, 32'h80000000, 32'h04000000, 31'd5, 32'h80000000});
        send_element({1'b0, 32'h7fffffff, 32'h7fffffff, 32'h00000000, 31'h7fffffff,
                      32'h7fffffff});
        drain();
        write_reg(rmsp_pkg::REG_EPS, 25'h1000000);
        write_reg(rmsp_pkg::REG_RHO, 25'd15099494);
        send_element({1'b0, 32'h00800000, 32'hff800000, 32'h00100000, 31'h00400000,
                      32'hffe00000});
        drain();

        // Random phases over register settings and flow-control mixes
        for (int ph = 0; ph < 8; ph++)
        begin
            if (ph == 7)
            begin
                write_reg(rmsp_pkg::REG_LR, 25'h1000000);
                write_reg(rmsp_pkg::REG_RHO, 25'h1000000);
                write_reg(rmsp_pkg::REG_MF, 25'd0);
                write_reg(rmsp_pkg::REG_EPS, 25'd0);
            end
            else
            begin
                write_reg(rmsp_pkg::REG_LR, $urandom_range(3) == 0 ? 25'($urandom) :
                          25'($urandom_range(16777216)));
                write_reg(rmsp_pkg::REG_RHO, 25'($urandom_range(16777216)));
                write_reg(rmsp_pkg::REG_MF, 25'($urandom_range(16777216)));
                write_reg(rmsp_pkg::REG_EPS, $urandom_range(1) ? 25'($urandom_range(16)) :
                          25'($urandom));
            end
            write_reg(rmsp_pkg::REG_CEN, 25'(ph % 2));
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
                default: begin send_idle_pct = 13; recv_stall_pct = 13; end
            endcase
            for (int i = 0; i < 235; i++)
                send_element(rand_element());
            drain();
            send_idle_pct = 0;
            recv_stall_pct = 0;
        end

        if (board.mismatches == 0 && board.exp_data.size() == 0)
            $display("PASS rmsprop_optimizer_update_unit");
        else
            $display("FAIL rmsprop_optimizer_update_unit");
        $finish;
    end
endmodule

`default_nettype wire
